// ----- rtl/core/wlan_rx_address_and_duplicate_filter_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the receive address and duplicate filter
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef WLAN_RX_ADDRESS_AND_DUPLICATE_FILTER_UNIT_MACROS_SVH
`define WLAN_RX_ADDRESS_AND_DUPLICATE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WRXDF_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WRXDF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/wrxdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Receive address and duplicate filter package
// Types, codes and constants shared by the filter's modules.
// ----------------------------------------------------------------------------
package wrxdf_pkg;

  localparam int unsigned TableEntriesDef = 32;
  localparam int unsigned QueueDepth      = 2;

  localparam int unsigned AddrW   = 48;
  localparam int unsigned SeqW    = 12;
  localparam int unsigned StampW  = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 48;

  localparam logic [WindowW-1:0] DupWindowRst = 16'd100;

  // Group bit of the first address byte.
  localparam logic [AddrW-1:0] GroupBit  = 48'h0100_0000_0000;
  localparam logic [AddrW-1:0] Broadcast = 48'hFFFF_FFFF_FFFF;

  localparam logic [CfgIdxW-1:0] CfgOwnAddr   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgNetworkId = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgDupWindow = 8'd2;

  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_NET      = 3'd1,
    REASON_OWN      = 3'd2,
    REASON_NOT_ADDR = 3'd3,
    REASON_DUP      = 3'd4
  } drop_reason_e;

  // A classified header waiting for the table stage.
  typedef struct packed {
    drop_reason_e      reason;
    logic [AddrW-1:0]  src;
    logic [SeqW-1:0]   seq;
    logic [StampW-1:0] now;
  } queue_item_t;

  typedef struct packed {
    logic         valid;
    logic         accept;
    drop_reason_e reason;
  } result_t;

endpackage

// ----- rtl/core/wrxdf_front.sv -----
// ----------------------------------------------------------------------------
// Filter front end
// Takes a header request and classifies it against network and own address.
// ----------------------------------------------------------------------------
module wrxdf_front (
  input  logic                          req_i,
  input  logic [wrxdf_pkg::AddrW-1:0]   dest_address_i,
  input  logic [wrxdf_pkg::AddrW-1:0]   source_address_i,
  input  logic [wrxdf_pkg::AddrW-1:0]   net_address_i,
  input  logic [wrxdf_pkg::SeqW-1:0]    seq_number_i,
  input  logic [wrxdf_pkg::StampW-1:0]  now_ms_i,
  input  logic [wrxdf_pkg::AddrW-1:0]   own_address_i,
  input  logic [wrxdf_pkg::AddrW-1:0]   network_id_i,
  output logic                          push_o,
  output wrxdf_pkg::queue_item_t        item_o
);
  import wrxdf_pkg::*;

  drop_reason_e reason;

  // The first failing test sets the reason.
  always_comb begin
    if (net_address_i != network_id_i) begin
      reason = REASON_NET;
    end else if (source_address_i == own_address_i) begin
      reason = REASON_OWN;
    end else if (dest_address_i != Broadcast &&
                 (dest_address_i & ~GroupBit) != own_address_i) begin
      reason = REASON_NOT_ADDR;
    end else begin
      reason = REASON_NONE;
    end
  end

  assign push_o      = req_i;
  assign item_o.reason = reason;
  assign item_o.src  = source_address_i;
  assign item_o.seq  = seq_number_i;
  assign item_o.now  = now_ms_i;

endmodule

// ----- rtl/core/wrxdf_queue.sv -----
// ----------------------------------------------------------------------------
// Filter request queue
// Short first-in first-out buffer between the front end and the table stage.
// ----------------------------------------------------------------------------
module wrxdf_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  wrxdf_pkg::queue_item_t item_i,
  output logic                   full_o,
  output logic                   valid_o,
  output wrxdf_pkg::queue_item_t item_o,
  input  logic                   pop_i
);
  import wrxdf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  queue_item_t     store_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/core/wrxdf_back.sv -----
// ----------------------------------------------------------------------------
// Filter table stage
// Scans the source table, runs the duplicate test and reports each result.
// ----------------------------------------------------------------------------
module wrxdf_back #(
  parameter int unsigned TableEntries = wrxdf_pkg::TableEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  wrxdf_pkg::queue_item_t         q_item_i,
  output logic                           q_pop_o,
  input  logic [wrxdf_pkg::WindowW-1:0]  dup_window_i,
  output wrxdf_pkg::result_t             result_o
);
  import wrxdf_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [StampW-1:0] stamp;
    logic [SeqW-1:0]   seq;
  } entry_t;

  entry_t mem [TableEntries];
  logic [TableEntries-1:0] valid_q;

  state_e            state_q, state_d;
  result_t           res_q, res_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pipe_q;
  logic [StampW-1:0] oldest_q, oldest_d;
  logic [IdxW-1:0]   pick_q, pick_d;
  logic              hit_q, hit_d;
  logic [IdxW-1:0]   sel_idx_q, sel_idx_d;
  logic [StampW-1:0] sel_time_q, sel_time_d;
  logic [SeqW-1:0]   sel_seq_q, sel_seq_d;
  queue_item_t       cur_q, cur_d;

  logic              rd_issue;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   rd_idx_q;
  entry_t            rd_data_q;
  logic              rd_vld_q;
  entry_t            rd_entry;

  logic [StampW-1:0] elapsed;
  logic [SeqW-1:0]   seq_diff;
  logic              is_dup;
  logic              we;
  entry_t            wdata;

  assign rd_issue = (state_q == S_SCAN) && (cnt_q < CntW'(TableEntries));
  assign rd_addr  = cnt_q[IdxW-1:0];
  // An entry never written since reset holds all zero.
  assign rd_entry = rd_vld_q ? rd_data_q : '0;

  assign elapsed  = cur_q.now - sel_time_q;
  assign seq_diff = cur_q.seq - sel_seq_q;
  // Within the window, a sequence that is equal or older under wrap repeats.
  assign is_dup   = (elapsed <= {{(StampW-WindowW){1'b0}}, dup_window_i}) &&
                    (seq_diff == '0 || seq_diff[SeqW-1]);

  assign wdata.addr  = cur_q.src;
  assign wdata.stamp = is_dup ? '0 : cur_q.now;
  assign wdata.seq   = is_dup ? '0 : cur_q.seq;

  always_comb begin
    state_d    = state_q;
    res_d      = '0;
    cnt_d      = cnt_q;
    oldest_d   = oldest_q;
    pick_d     = pick_q;
    hit_d      = hit_q;
    sel_idx_d  = sel_idx_q;
    sel_time_d = sel_time_q;
    sel_seq_d  = sel_seq_q;
    cur_d      = cur_q;
    q_pop_o    = 1'b0;
    we         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          if (q_item_i.reason != REASON_NONE) begin
            res_d.valid  = 1'b1;
            res_d.accept = 1'b0;
            res_d.reason = q_item_i.reason;
          end else begin
            state_d  = S_SCAN;
            cnt_d    = '0;
            oldest_d = '1;
            pick_d   = '0;
          end
        end
      end
      S_SCAN: begin
        if (rd_issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (pipe_q) begin
          if (rd_entry.addr == cur_q.src) begin
            hit_d      = 1'b1;
            sel_idx_d  = rd_idx_q;
            sel_time_d = rd_entry.stamp;
            sel_seq_d  = rd_entry.seq;
            state_d    = S_DECIDE;
          end else begin
            // Later entries win ties for the oldest time.
            if (rd_entry.stamp <= oldest_q) begin
              oldest_d = rd_entry.stamp;
              pick_d   = rd_idx_q;
            end
            if (rd_idx_q == IdxW'(TableEntries - 1)) begin
              hit_d      = 1'b0;
              sel_idx_d  = pick_d;
              sel_time_d = '0;
              sel_seq_d  = '0;
              state_d    = S_DECIDE;
            end
          end
        end
      end
      S_DECIDE: begin
        // A replaced entry takes the new source even when the frame drops.
        we           = !hit_q || !is_dup;
        res_d.valid  = 1'b1;
        res_d.accept = !is_dup;
        res_d.reason = is_dup ? REASON_DUP : REASON_NONE;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= '0;
      cnt_q   <= '0;
      pipe_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      cnt_q   <= cnt_d;
      pipe_q  <= rd_issue;
      if (we) begin
        valid_q[sel_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    oldest_q   <= oldest_d;
    pick_q     <= pick_d;
    hit_q      <= hit_d;
    sel_idx_q  <= sel_idx_d;
    sel_time_q <= sel_time_d;
    sel_seq_q  <= sel_seq_d;
    cur_q      <= cur_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[sel_idx_q] <= wdata;
    end
    if (rd_issue) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= valid_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  assign result_o = res_q;

endmodule

// ----- rtl/core/wlan_rx_address_and_duplicate_filter_unit.sv -----
// ----------------------------------------------------------------------------
// Receive address and duplicate filter
// Drops foreign, self-sent, unaddressed and repeated frame headers.
// ----------------------------------------------------------------------------
// Usage: a header request is taken at a rising edge where start is high and
// busy is low. Each request gives one result on accept_o and drop_reason_o,
// shown for exactly one cycle while result_valid_o is high; the receiver
// cannot hold results off. Registers are written over the cfg channel
// (valid/ready, ready always high) while no request is in flight.
// The front end classifies a request in the cycle it is taken and puts it in
// a two-entry queue, so busy rises only when that queue is full.
// A header that fails the address tests goes through the queue and is reported
// from the result register once the table stage pops it. A header that passes
// scans the source table one entry per cycle through a single read port,
// stopping at the first hit; a miss reads every entry. The table stage handles
// one request at a time and pops the next only when back in idle, so the scan
// sets the rate, while the queue keeps taking requests until it is full.
// Reset clears the registers to their defaults and marks every table entry
// as zero through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module wlan_rx_address_and_duplicate_filter_unit #(
  parameter int unsigned TableEntries = wrxdf_pkg::TableEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [wrxdf_pkg::AddrW-1:0]     dest_address_i,
  input  logic [wrxdf_pkg::AddrW-1:0]     source_address_i,
  input  logic [wrxdf_pkg::AddrW-1:0]     net_address_i,
  input  logic [wrxdf_pkg::SeqW-1:0]      seq_number_i,
  input  logic [wrxdf_pkg::StampW-1:0]    now_ms_i,
  output logic                            result_valid_o,
  output logic                            accept_o,
  output logic [2:0]                      drop_reason_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wrxdf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wrxdf_pkg::CfgDataW-1:0]  cfg_data_i
);
  import wrxdf_pkg::*;

  logic [AddrW-1:0]   own_address_q;
  logic [AddrW-1:0]   network_id_q;
  logic [WindowW-1:0] dup_window_q;

  logic        push;
  queue_item_t front_item;
  logic        q_full;
  logic        q_valid;
  queue_item_t q_item;
  logic        q_pop;
  result_t     result;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= '0;
      network_id_q  <= '0;
      dup_window_q  <= DupWindowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgOwnAddr:   own_address_q <= cfg_data_i[AddrW-1:0];
        CfgNetworkId: network_id_q  <= cfg_data_i[AddrW-1:0];
        CfgDupWindow: dup_window_q  <= cfg_data_i[WindowW-1:0];
        default: ;
      endcase
    end
  end

  wrxdf_front u_front (
    .req_i            (start && !busy),
    .dest_address_i   (dest_address_i),
    .source_address_i (source_address_i),
    .net_address_i    (net_address_i),
    .seq_number_i     (seq_number_i),
    .now_ms_i         (now_ms_i),
    .own_address_i    (own_address_q),
    .network_id_i     (network_id_q),
    .push_o           (push),
    .item_o           (front_item)
  );

  wrxdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  wrxdf_back #(
    .TableEntries (TableEntries)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .dup_window_i (dup_window_q),
    .result_o     (result)
  );

  assign result_valid_o = result.valid;
  assign accept_o       = result.accept;
  assign drop_reason_o  = 3'(result.reason);

endmodule

// ----- rtl/core/wrxdf_checker.sv -----
// ----------------------------------------------------------------------------
// Filter port checker
// Concurrent checks on the filter's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "wlan_rx_address_and_duplicate_filter_unit_macros.svh"

module wrxdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic       accept_o,
  input logic [2:0] drop_reason_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);
  import wrxdf_pkg::*;

  // A passed frame always carries the no-drop code, and a dropped one never.
  `WRXDF_ASSERT(a_accept_matches_reason, result_valid_o, accept_o == (drop_reason_o == REASON_NONE), "accept flag disagrees with drop reason")

  // Only the defined drop codes ever appear on a result.
  `WRXDF_ASSERT(a_reason_defined, result_valid_o, drop_reason_o <= REASON_DUP, "undefined drop reason")

  // The queue can only fill after a request is taken.
  `WRXDF_ASSERT(a_busy_after_request, $rose(busy), $past(start && !busy), "busy rose without a taken request")

  // Configuration writes are never refused.
  `WRXDF_ASSERT_NEXT(a_cfg_always_ready, cfg_valid_i, cfg_ready_o, "configuration port not ready")

endmodule

bind wlan_rx_address_and_duplicate_filter_unit wrxdf_checker u_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the receive address and duplicate filter
// Feeds frame header requests through the start/busy handshake under several
// register settings and checks every verdict against an in-bench model of the
// address tests and the per-source sequence table.
// ----------------------------------------------------------------------------
module tb_top;
  import wrxdf_pkg::*;

  localparam int unsigned TableEntries = TableEntriesDef;
  localparam int unsigned PoolSize = 48;
  localparam int unsigned FramesPerPhase = 190;
  localparam int unsigned RandomPhases = 8;

  localparam logic [CfgIdxW-1:0] CfgUnmappedLow = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgUnmappedTop = 8'hFF;

  localparam logic [AddrW-1:0] OwnA = 48'h0A1B_2C3D_4E5F;
  localparam logic [AddrW-1:0] NetA = 48'h7E00_5A5A_C3C3;
  localparam logic [AddrW-1:0] PeerA = 48'h0C00_0000_0101;
  localparam logic [AddrW-1:0] PeerB = 48'h0C00_0000_0202;
  localparam logic [AddrW-1:0] StrangerDst = 48'h0123_4567_89AB;

  typedef struct packed {
    logic [AddrW-1:0]  dst;
    logic [AddrW-1:0]  src;
    logic [AddrW-1:0]  net;
    logic [SeqW-1:0]   seq;
    logic [StampW-1:0] now;
  } frame_hdr_t;

  typedef struct packed {
    logic         accept;
    drop_reason_e reason;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic hdr_start = 1'b0;
  logic hdr_busy;
  logic [AddrW-1:0] hdr_dst = '0;
  logic [AddrW-1:0] hdr_src = '0;
  logic [AddrW-1:0] hdr_net = '0;
  logic [SeqW-1:0] hdr_seq = '0;
  logic [StampW-1:0] hdr_now = '0;
  logic verdict_valid;
  logic verdict_accept;
  logic [2:0] verdict_reason;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Register copies as the block should hold them.
  logic [AddrW-1:0] cfg_own = '0;
  logic [AddrW-1:0] cfg_net = '0;
  logic [WindowW-1:0] cfg_window = DupWindowRst;

  // Source table copy, cleared as after reset.
  logic [AddrW-1:0] src_addr [TableEntries];
  logic [StampW-1:0] src_stamp [TableEntries];
  logic [SeqW-1:0] src_seq [TableEntries];

  frame_hdr_t hdr_pending[$];
  verdict_t verdict_due[$];
  frame_hdr_t next_hdr;
  verdict_t due_verdict;
  logic hdr_taken = 1'b0;
  logic sender_idle = 1'b1;
  int unsigned idle_left = 0;

  // Stimulus state: station pool, per-station sequence and a running clock.
  logic [AddrW-1:0] src_pool [PoolSize];
  logic [SeqW-1:0] seq_track [PoolSize];
  logic [StampW-1:0] now_clock = 32'd2000;

  int fail_count = 0;
  int verdicts_checked = 0;
  int settings_used = 1;
  int reason_seen [5] = '{default: 0};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  wlan_rx_address_and_duplicate_filter_unit #(
    .TableEntries(TableEntries)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (hdr_start),
    .busy            (hdr_busy),
    .dest_address_i  (hdr_dst),
    .source_address_i(hdr_src),
    .net_address_i   (hdr_net),
    .seq_number_i    (hdr_seq),
    .now_ms_i        (hdr_now),
    .result_valid_o  (verdict_valid),
    .accept_o        (verdict_accept),
    .drop_reason_o   (verdict_reason),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[AddrW-1:0];
  endfunction

  // Works out the verdict for one header and updates the table copy.
  function automatic verdict_t classify_frame(frame_hdr_t h);
    verdict_t v;
    int unsigned idx;
    int unsigned slot;
    logic hit;
    logic [StampW-1:0] oldest;
    logic [StampW-1:0] elapsed;
    logic [SeqW-1:0] seq_gap;
    v.reason = REASON_NONE;
    if (h.net != cfg_net) begin
      v.reason = REASON_NET;
    end else if (h.src == cfg_own) begin
      v.reason = REASON_OWN;
    end else if (h.dst != Broadcast && (h.dst & ~GroupBit) != cfg_own) begin
      v.reason = REASON_NOT_ADDR;
    end else begin
      hit = 1'b0;
      slot = 0;
      oldest = '1;
      for (idx = 0; idx < TableEntries && !hit; idx++) begin
        if (src_addr[idx] == h.src) begin
          slot = idx;
          hit = 1'b1;
        end else if (src_stamp[idx] <= oldest) begin
          // Ties go to the later entry.
          oldest = src_stamp[idx];
          slot = idx;
        end
      end
      if (!hit) begin
        src_addr[slot] = h.src;
        src_stamp[slot] = '0;
        src_seq[slot] = '0;
      end
      elapsed = h.now - src_stamp[slot];
      if (elapsed <= StampW'(cfg_window)) begin
        seq_gap = h.seq - src_seq[slot];
        if (seq_gap == '0 || seq_gap >= 12'd2048) begin
          v.reason = REASON_DUP;
        end
      end
      if (v.reason == REASON_NONE) begin
        src_stamp[slot] = h.now;
        src_seq[slot] = h.seq;
      end
    end
    v.accept = (v.reason == REASON_NONE);
    return v;
  endfunction

  function automatic void apply_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgOwnAddr: begin
        cfg_own = data[AddrW-1:0];
      end
      CfgNetworkId: begin
        cfg_net = data[AddrW-1:0];
      end
      CfgDupWindow: begin
        cfg_window = data[WindowW-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Header driver: presents the next pending request, after a random hold-off while sender_idle is set.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      hdr_start <= 1'b0;
    end else if (!hdr_start || hdr_taken) begin
      if (idle_left != 0) begin
        hdr_start <= 1'b0;
        idle_left = idle_left - 1;
      end else if (hdr_pending.size() != 0) begin
        next_hdr = hdr_pending.pop_front();
        hdr_dst <= next_hdr.dst;
        hdr_src <= next_hdr.src;
        hdr_net <= next_hdr.net;
        hdr_seq <= next_hdr.seq;
        hdr_now <= next_hdr.now;
        hdr_start <= 1'b1;
        idle_left = sender_idle ? $urandom_range(0, 4) : 0;
      end else begin
        hdr_start <= 1'b0;
      end
    end
  end

  // Monitor: checks verdicts, then records requests and register writes.
  always @(posedge clk_i) begin
    hdr_taken <= rst_ni && hdr_start && !hdr_busy;
    if (rst_ni) begin
      if (verdict_valid) begin
        if (verdict_due.size() == 0) begin
          $display("%0t: verdict with no request pending: accept %0b reason %0d",
                   $time, verdict_accept, verdict_reason);
          fail_count++;
        end else begin
          due_verdict = verdict_due.pop_front();
          if (verdict_accept !== due_verdict.accept) begin
            $display("%0t: accept expected %0b, got %0b",
                     $time, due_verdict.accept, verdict_accept);
            fail_count++;
          end
          if (verdict_reason !== due_verdict.reason) begin
            $display("%0t: drop reason expected %0d, got %0d",
                     $time, due_verdict.reason, verdict_reason);
            fail_count++;
          end
          reason_seen[int'(due_verdict.reason)]++;
          verdicts_checked++;
        end
      end
      if (hdr_start && !hdr_busy) begin
        verdict_due.push_back(classify_frame({hdr_dst, hdr_src, hdr_net, hdr_seq, hdr_now}));
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
      end
    end
  end

  task automatic add_hdr(logic [AddrW-1:0] dst, logic [AddrW-1:0] src,
                         logic [AddrW-1:0] net, logic [SeqW-1:0] seq,
                         logic [StampW-1:0] now);
    hdr_pending.push_back({dst, src, net, seq, now});
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (hdr_pending.size() != 0 || hdr_start || verdict_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Upper data bits of the window write are random, so masking is exercised.
  task automatic set_config(logic [AddrW-1:0] own, logic [AddrW-1:0] net,
                            logic [WindowW-1:0] win);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CfgOwnAddr, own);
    write_reg(CfgNetworkId, net);
    write_reg(CfgDupWindow, {junk, win});
    settings_used++;
  endtask

  // Mostly well-formed headers from a station pool with nearby sequence
  // numbers and a slowly advancing clock; the rest break one address test or are random.
  task automatic queue_random_frames(int unsigned count, int unsigned span);
    frame_hdr_t h;
    int unsigned n;
    int unsigned p;
    int unsigned kind;
    logic [SeqW-1:0] delta;
    logic [31:0] r32;
    p = 0;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        p = $urandom_range(0, span - 1);
      end
      if ($urandom_range(0, 99) == 0) begin
        now_clock = $urandom();
      end else if ($urandom_range(0, 3) != 0) begin
        now_clock = now_clock + $urandom_range(1, 60);
      end
      r32 = $urandom();
      case ($urandom_range(0, 9))
        0: delta = '0;
        1: delta = '1;
        2: delta = 12'd2048;
        3: delta = 12'd2047;
        4: delta = 12'(2040 + r32[3:0]);
        5: delta = r32[SeqW-1:0];
        default: delta = 12'(1 + r32[0]);
      endcase
      seq_track[p] = seq_track[p] + delta;
      h.src = src_pool[p];
      h.net = cfg_net;
      h.seq = seq_track[p];
      h.now = now_clock;
      case ($urandom_range(0, 2))
        0: h.dst = Broadcast;
        1: h.dst = cfg_own;
        default: h.dst = cfg_own | GroupBit;
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        r32 = $urandom();
        h.dst = rand_addr();
        h.src = rand_addr();
        h.net = rand_addr();
        h.seq = r32[SeqW-1:0];
        h.now = $urandom();
      end else if (kind < 12) begin
        h.net = cfg_net ^ (48'h1 << $urandom_range(0, AddrW - 1));
      end else if (kind < 16) begin
        h.src = cfg_own;
      end else if (kind < 22) begin
        h.dst = cfg_own ^ (48'h1 << $urandom_range(0, AddrW - 1));
      end
      hdr_pending.push_back(h);
    end
  endtask

  initial begin
    int unsigned i;
    int unsigned phase;
    for (i = 0; i < TableEntries; i++) begin
      src_addr[i] = '0;
      src_stamp[i] = '0;
      src_seq[i] = '0;
    end
    src_pool[0] = '0;
    src_pool[1] = Broadcast;
    for (i = 2; i < PoolSize; i++) begin
      src_pool[i] = rand_addr();
    end
    for (i = 0; i < PoolSize; i++) begin
      seq_track[i] = '0;
    end

    // Default registers: own source, other network, then a fresh station.
    add_hdr('0, '0, '0, 12'd3, 32'd10);
    add_hdr('0, PeerA, 48'h1, 12'd3, 32'd10);
    add_hdr('0, 48'h1, '0, 12'd0, 32'd500);
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    set_config(OwnA, NetA, DupWindowRst);
    // Check order, group bit, broadcast and the duplicate rules.
    add_hdr(OwnA, PeerA, ~NetA, 12'd1, 32'd1000);
    add_hdr(OwnA, OwnA, NetA, 12'd1, 32'd1000);
    add_hdr(StrangerDst, OwnA, ~NetA, 12'd1, 32'd1000);
    add_hdr(StrangerDst, OwnA, NetA, 12'd1, 32'd1000);
    add_hdr(OwnA ^ 48'h1, PeerA, NetA, 12'd1, 32'd1000);
    add_hdr(OwnA | GroupBit, PeerA, NetA, 12'd5, 32'd1000);
    add_hdr(Broadcast, PeerA, NetA, 12'd5, 32'd1050);
    add_hdr(Broadcast, PeerA, NetA, 12'd4, 32'd1060);
    add_hdr(OwnA, PeerA, NetA, 12'd2053, 32'd1070);
    add_hdr(OwnA, PeerA, NetA, 12'd2052, 32'd1080);
    add_hdr(OwnA, PeerA, NetA, 12'd2052, 32'd1180);
    add_hdr(OwnA, PeerA, NetA, 12'd2052, 32'd1181);
    // A zero source matches the cleared entries.
    add_hdr(OwnA, '0, NetA, 12'd0, 32'd50);
    add_hdr(OwnA, '0, NetA, 12'd1, 32'd50);
    // A new entry starts at time zero, so an early frame with sequence zero
    // is a duplicate and the entry still takes the address.
    add_hdr(OwnA, PeerB, NetA, 12'd0, 32'd30);
    add_hdr(OwnA, PeerB, NetA, 12'd7, 32'd30);
    // Clock and sequence wrap on an all-ones source.
    add_hdr(Broadcast, Broadcast, NetA, 12'd4095, 32'hFFFF_FFF0);
    add_hdr(Broadcast, Broadcast, NetA, 12'd4095, 32'h0000_0010);
    add_hdr(Broadcast, Broadcast, NetA, 12'd0, 32'h0000_0010);
    add_hdr(GroupBit, PeerB, NetA, 12'd9, 32'd40);
    wait_idle();

    // Writes past the register list must change nothing.
    write_reg(CfgUnmappedLow, rand_addr());
    write_reg(CfgUnmappedTop, rand_addr());
    write_reg(CfgDupWindow, 48'h1234_5678_0005);
    settings_used++;
    add_hdr(OwnA, PeerA, NetA, 12'd2052, 32'd1186);
    add_hdr(OwnA, PeerA, NetA, 12'd2052, 32'd1187);
    wait_idle();

    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: set_config(rand_addr(), rand_addr(), 16'd100);
        1: set_config(Broadcast, rand_addr(), 16'd0);
        2: set_config('0, rand_addr(), 16'hFFFF);
        3: set_config(rand_addr(), '0, 16'd1);
        4: set_config(rand_addr(), Broadcast, 16'($urandom_range(0, 300)));
        5: set_config(rand_addr() | GroupBit, rand_addr(), 16'd0);
        6: set_config(rand_addr(), rand_addr(), 16'hFFFF);
        default: set_config(rand_addr(), rand_addr(), 16'($urandom_range(2, 200)));
      endcase
      sender_idle = (phase != 2 && phase != 6);
      queue_random_frames(FramesPerPhase, (phase % 2 == 0) ? PoolSize : 24);
      wait_idle();
    end

    repeat (TableEntries + 8) @(posedge clk_i);
    $display("Checked %0d frame verdicts over %0d register settings.",
             verdicts_checked, settings_used);
    $display("Accepted %0d; dropped for network %0d, own source %0d, address %0d, repeat %0d.",
             reason_seen[0], reason_seen[1], reason_seen[2], reason_seen[3], reason_seen[4]);
    if (fail_count == 0 && verdict_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d verdicts outstanding.", verdict_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/wrxdf_pkg.sv
rtl/core/wrxdf_front.sv
rtl/core/wrxdf_queue.sv
rtl/core/wrxdf_back.sv
rtl/core/wlan_rx_address_and_duplicate_filter_unit.sv
rtl/core/wrxdf_checker.sv
verif/tb_top.sv
